[hw/rtl/spq_pkg.sv]
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VAL_W        = 32;
  localparam int PRI_W        = 8;
  localparam int OCC_W        = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [PRI_W-1:0]        pri;
  } entry_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] out_value;
    logic [PRI_W-1:0]        out_priority;
    logic [OCC_W-1:0]        occupancy;
  } result_t;

endpackage

[hw/rtl/spq_cmd_if.sv]
interface spq_cmd_if;
  logic                                valid;
  logic                                ready;
  logic                                command;
  logic signed [spq_pkg::VAL_W-1:0]    item_value;
  logic [spq_pkg::PRI_W-1:0]           item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink   (input valid, command, item_value, item_priority, output ready);
endinterface

[hw/rtl/spq_res_if.sv]
interface spq_res_if;
  logic                                valid;
  logic                                ready;
  spq_pkg::status_t                    status;
  logic signed [spq_pkg::VAL_W-1:0]    out_value;
  logic [spq_pkg::PRI_W-1:0]           out_priority;
  logic [spq_pkg::OCC_W-1:0]           occupancy;

  modport source (output valid, status, out_value, out_priority, occupancy, input ready);
  modport sink   (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

[hw/rtl/spq_core.sv]
module spq_core #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  spq_cmd_if.sink          cmd,
  output spq_pkg::result_t res,
  output logic             res_valid,
  input  logic             res_ready
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_CNT = CW'(1);

  typedef enum logic [2:0] {
    IDLE,
    ENQ_SCAN,
    ENQ_PUT,
    DEQ_HEAD,
    DEQ_SHIFT,
    DONE
  } state_t;

  state_t           state;
  logic [CW-1:0]    cnt;
  logic [AW-1:0]    idx;
  spq_pkg::entry_t  new_ent;

  spq_pkg::entry_t  mem [CAPACITY];
  spq_pkg::entry_t  rdata;
  spq_pkg::entry_t  wdata;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             we;
  logic             lower;
  logic [AW-1:0]    last_idx;

  assign lower     = rdata.pri < new_ent.pri;
  assign last_idx  = AW'(cnt - ONE_CNT);
  assign cmd.ready = (state == IDLE);
  assign res_valid = (state == DONE);

  // one read and one write per cycle; the read for the next slot overlaps the move
  always_comb begin
    raddr = idx;
    waddr = idx;
    wdata = new_ent;
    we    = 1'b0;
    case (state)
      IDLE: begin
        raddr = (cmd.command == spq_pkg::CMD_DEQ) ? '0 : last_idx;
      end
      ENQ_SCAN: begin
        we    = 1'b1;
        waddr = AW'(idx + 1'b1);
        raddr = AW'(idx - 1'b1);
        if (lower) begin
          wdata = rdata;
        end
      end
      ENQ_PUT: begin
        we    = 1'b1;
        waddr = '0;
      end
      DEQ_HEAD: begin
        raddr = AW'(1);
      end
      DEQ_SHIFT: begin
        we    = 1'b1;
        waddr = AW'(idx - 1'b1);
        wdata = rdata;
        raddr = AW'(idx + 1'b1);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.valid) begin
            new_ent.val          <= cmd.item_value;
            new_ent.pri          <= cmd.item_priority;
            res.out_value        <= '0;
            res.out_priority     <= '0;
            res.occupancy        <= spq_pkg::OCC_W'(cnt);
            if (cmd.command == spq_pkg::CMD_ENQ) begin
              if (cnt == CAP_CNT) begin
                res.status <= spq_pkg::ST_FULL;
                state      <= DONE;
              end else if (cnt == '0) begin
                state <= ENQ_PUT;
              end else begin
                idx   <= last_idx;
                state <= ENQ_SCAN;
              end
            end else begin
              if (cnt == '0) begin
                res.status <= spq_pkg::ST_EMPTY;
                state      <= DONE;
              end else begin
                state <= DEQ_HEAD;
              end
            end
          end
        end
        ENQ_SCAN: begin
          if (lower) begin
            if (idx == '0) begin
              state <= ENQ_PUT;
            end else begin
              idx <= AW'(idx - 1'b1);
            end
          end else begin
            cnt           <= cnt + ONE_CNT;
            res.occupancy <= spq_pkg::OCC_W'(cnt + ONE_CNT);
            res.status    <= spq_pkg::ST_ENQUEUED;
            state         <= DONE;
          end
        end
        ENQ_PUT: begin
          cnt           <= cnt + ONE_CNT;
          res.occupancy <= spq_pkg::OCC_W'(cnt + ONE_CNT);
          res.status    <= spq_pkg::ST_ENQUEUED;
          state         <= DONE;
        end
        DEQ_HEAD: begin
          res.out_value    <= rdata.val;
          res.out_priority <= rdata.pri;
          res.status       <= spq_pkg::ST_DEQUEUED;
          if (cnt == ONE_CNT) begin
            cnt           <= '0;
            res.occupancy <= '0;
            state         <= DONE;
          end else begin
            idx   <= AW'(1);
            state <= DEQ_SHIFT;
          end
        end
        DEQ_SHIFT: begin
          if (idx == last_idx) begin
            cnt           <= cnt - ONE_CNT;
            res.occupancy <= spq_pkg::OCC_W'(cnt - ONE_CNT);
            state         <= DONE;
          end else begin
            idx <= AW'(idx + 1'b1);
          end
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/spq_res_reg.sv]
module spq_res_reg (
  input  logic             clk,
  input  logic             rst,
  input  spq_pkg::result_t push_res,
  input  logic             push_valid,
  output logic             push_ready,
  spq_res_if.source        res
);

  logic             full;
  spq_pkg::result_t held;

  assign push_ready = !full || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push_ready) begin
      full <= push_valid;
    end
    if (push_valid && push_ready) begin
      held <= push_res;
    end
  end

  assign res.valid        = full;
  assign res.status       = held.status;
  assign res.out_value    = held.out_value;
  assign res.out_priority = held.out_priority;
  assign res.occupancy    = held.occupancy;

endmodule

[hw/rtl/sorted_priority_queue_top.sv]
// channel | dir | payload                                      | role
// cmd     | in  | command, item_value, item_priority           | enqueue or dequeue request
// res     | out | status, out_value, out_priority, occupancy   | one result per request
//
// one request at a time; slots move one per cycle through the slot memory
// (one read and one write port): an enqueue scans from the tail, shifting lower-priority
// entries up; a dequeue takes the head and shifts the rest down; full or empty requests are rejected
// cmd.ready is high only between requests; a result waits in an output register
// rst is synchronous; entry count clears, slot contents need no clearing
module sorted_priority_queue_top #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst,
  spq_cmd_if.sink   cmd,
  spq_res_if.source res
);

  spq_pkg::result_t core_res;
  logic             core_valid;
  logic             core_ready;

  spq_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .res       (core_res),
    .res_valid (core_valid),
    .res_ready (core_ready)
  );

  spq_res_reg u_res_reg (
    .clk        (clk),
    .rst        (rst),
    .push_res   (core_res),
    .push_valid (core_valid),
    .push_ready (core_ready),
    .res        (res)
  );

endmodule

[hw/rtl/spq_checker.sv]
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             res_valid,
  input logic                             res_ready,
  input spq_pkg::status_t                 res_status,
  input logic signed [spq_pkg::VAL_W-1:0] res_value,
  input logic [spq_pkg::PRI_W-1:0]        res_priority,
  input logic [spq_pkg::OCC_W-1:0]        res_occupancy
);

  localparam logic [spq_pkg::OCC_W-1:0] CAP_OCC = spq_pkg::OCC_W'(CAPACITY);

  // a stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) &&
      $stable(res_value) && $stable(res_priority) && $stable(res_occupancy))
    else $error("result beat changed while stalled");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status != spq_pkg::ST_DEQUEUED) |->
      (res_value == '0) && (res_priority == '0))
    else $error("nonzero payload on a result without a dequeue");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == spq_pkg::ST_EMPTY) |-> res_occupancy == '0)
    else $error("empty status with entries held");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == spq_pkg::ST_FULL) |-> res_occupancy == CAP_OCC)
    else $error("full status below capacity");

endmodule

bind sorted_priority_queue_top spq_checker #(
  .CAPACITY(CAPACITY)
) u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_status    (res.status),
  .res_value     (res.out_value),
  .res_priority  (res.out_priority),
  .res_occupancy (res.occupancy)
);
